// ===== hdl/fct_pkg.sv =====
// Package for the fault code table: table sizing, request kinds, the
// table entry layout and the health score mapping.
// No dependencies; used by fault_code_table_core.
package fct_pkg;

    localparam int TableDepth = 16;
    localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam int CntW       = $clog2(TableDepth + 1);

    localparam logic [7:0] OccMax      = 8'd255;
    localparam logic [6:0] HealthNone  = 7'd100;
    localparam logic [6:0] HealthLow   = 7'd75;
    localparam logic [6:0] HealthMid   = 7'd50;
    localparam logic [6:0] HealthHigh  = 7'd25;
    localparam int         LowLimit    = 2;
    localparam int         MidLimit    = 5;

    typedef enum logic [1:0] {
        KindReport   = 2'd0,
        KindClearOne = 2'd1,
        KindClearAll = 2'd2,
        KindLookup   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] code;
        logic        active;
        logic [7:0]  occ;
        logic [31:0] first;
        logic [31:0] last;
    } t_entry;

    function automatic logic [6:0] health_of(input logic [CntW-1:0] n);
        logic [6:0] h;
        if (n == '0) begin
            h = HealthNone;
        end else if (32'(n) <= LowLimit) begin
            h = HealthLow;
        end else if (32'(n) <= MidLimit) begin
            h = HealthMid;
        end else begin
            h = HealthHigh;
        end
        return h;
    endfunction

endpackage

// ===== hdl/fault_code_table_core.sv =====
// Fault code table: sequencer, entry memory and result register.
// Depends on fct_pkg for sizing, request kinds and the entry layout.
//
// Usage: a request (kind, fault code, active flag, current time) is taken
// when i_valid is high and o_stall is low. o_stall stays high from the
// accepting edge until the result has been taken, so one request is in
// flight at a time. The result is held on the o_ ports with o_valid high
// until an edge at which i_stall is low; while the receiver stalls,
// nothing in the result changes.
// Search: the sequencer reads the entry memory through its single registered
// read port, a read state and a check state per entry examined, and a clear
// of one code then moves each later entry down one place, with a read state
// and a write state per entry moved. A clear of all skips the search. The
// next request is taken only once the sequencer has returned to idle after
// the result has been taken. Reset (synchronous, active low) empties the
// table and returns to idle; no entry beyond the fill count is ever used.
module fault_code_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_fault_code,
    input  logic        i_active,
    input  logic [31:0] i_now,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic        o_code_active,
    output logic [7:0]  o_occurrences,
    output logic [31:0] o_first_seen,
    output logic [31:0] o_last_seen,
    output logic [4:0]  o_stored_count,
    output logic [4:0]  o_active_total,
    output logic [6:0]  o_health_score,
    output logic        o_dropped
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    t_state                     r_state, n_state;
    fct_pkg::t_kind             r_kind, n_kind;
    logic [15:0]                r_code, n_code;
    logic                       r_act, n_act;
    logic [31:0]                r_now, n_now;
    logic [fct_pkg::CntW-1:0]   r_idx, n_idx;
    logic [fct_pkg::CntW-1:0]   r_fill, n_fill;
    logic [fct_pkg::CntW-1:0]   r_act_cnt, n_act_cnt;
    logic                       r_found, n_found;
    logic                       r_code_active, n_code_active;
    logic [7:0]                 r_occ, n_occ;
    logic [31:0]                r_first, n_first;
    logic [31:0]                r_last, n_last;
    logic                       r_dropped, n_dropped;

    fct_pkg::t_entry            r_mem [fct_pkg::TableDepth];
    fct_pkg::t_entry            r_rd;
    fct_pkg::t_entry            wr_data;
    fct_pkg::t_entry            upd;
    logic                       wr_en;
    logic [fct_pkg::IdxW-1:0]   wr_addr;
    logic [fct_pkg::IdxW-1:0]   rd_addr;
    logic [fct_pkg::CntW-1:0]   idx_inc;

    assign idx_inc = fct_pkg::CntW'(r_idx + 1'b1);

    // Entry as it stands after a report of a held code.
    always_comb begin
        upd        = r_rd;
        upd.active = r_act;
        upd.last   = r_now;
        if (r_act && (r_rd.occ != fct_pkg::OccMax)) begin
            upd.occ = r_rd.occ + 8'd1;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_code        = r_code;
        n_act         = r_act;
        n_now         = r_now;
        n_idx         = r_idx;
        n_fill        = r_fill;
        n_act_cnt     = r_act_cnt;
        n_found       = r_found;
        n_code_active = r_code_active;
        n_occ         = r_occ;
        n_first       = r_first;
        n_last        = r_last;
        n_dropped     = r_dropped;
        wr_en         = 1'b0;
        wr_addr       = r_idx[fct_pkg::IdxW-1:0];
        wr_data       = upd;
        rd_addr       = r_idx[fct_pkg::IdxW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind        = fct_pkg::t_kind'(i_kind);
                    n_code        = i_fault_code;
                    n_act         = i_active;
                    n_now         = i_now;
                    n_idx         = '0;
                    n_found       = 1'b0;
                    n_code_active = 1'b0;
                    n_occ         = '0;
                    n_first       = '0;
                    n_last        = '0;
                    n_dropped     = 1'b0;
                    if (fct_pkg::t_kind'(i_kind) == fct_pkg::KindClearAll) begin
                        n_fill    = '0;
                        n_act_cnt = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_idx < r_fill) begin
                    n_state = S_CHECK;
                end else begin
                    // Code not held.
                    n_state = S_DONE;
                    if (r_kind == fct_pkg::KindReport && r_act) begin
                        if (r_fill < fct_pkg::CntW'(fct_pkg::TableDepth)) begin
                            wr_en         = 1'b1;
                            wr_addr       = r_fill[fct_pkg::IdxW-1:0];
                            wr_data       = '{code: r_code, active: 1'b1, occ: 8'd1,
                                              first: r_now, last: r_now};
                            n_fill        = fct_pkg::CntW'(r_fill + 1'b1);
                            n_act_cnt     = fct_pkg::CntW'(r_act_cnt + 1'b1);
                            n_found       = 1'b1;
                            n_code_active = 1'b1;
                            n_occ         = 8'd1;
                            n_first       = r_now;
                            n_last        = r_now;
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (r_rd.code == r_code) begin
                    n_found = 1'b1;
                    case (r_kind)
                        fct_pkg::KindReport: begin
                            wr_en         = 1'b1;
                            n_act_cnt     = fct_pkg::CntW'(r_act_cnt
                                            - fct_pkg::CntW'(r_rd.active)
                                            + fct_pkg::CntW'(r_act));
                            n_code_active = upd.active;
                            n_occ         = upd.occ;
                            n_first       = upd.first;
                            n_last        = upd.last;
                            n_state       = S_DONE;
                        end
                        fct_pkg::KindClearOne: begin
                            n_act_cnt = fct_pkg::CntW'(r_act_cnt
                                        - fct_pkg::CntW'(r_rd.active));
                            n_state   = S_SHIFT_RD;
                        end
                        default: begin
                            n_code_active = r_rd.active;
                            n_occ         = r_rd.occ;
                            n_first       = r_rd.first;
                            n_last        = r_rd.last;
                            n_state       = S_DONE;
                        end
                    endcase
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SEARCH;
                end
            end
            S_SHIFT_RD: begin
                // Pull the next entry down over the removed one.
                if (idx_inc < r_fill) begin
                    rd_addr = idx_inc[fct_pkg::IdxW-1:0];
                    n_state = S_SHIFT_WR;
                end else begin
                    n_fill  = fct_pkg::CntW'(r_fill - 1'b1);
                    n_state = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_data = r_rd;
                n_idx   = idx_inc;
                n_state = S_SHIFT_RD;
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_act_cnt <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_act_cnt <= n_act_cnt;
            r_idx     <= n_idx;
            r_found   <= n_found;
            r_dropped <= n_dropped;
        end
        r_kind        <= n_kind;
        r_code        <= n_code;
        r_act         <= n_act;
        r_now         <= n_now;
        r_code_active <= n_code_active;
        r_occ         <= n_occ;
        r_first       <= n_first;
        r_last        <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_found        = r_found;
    assign o_code_active  = r_code_active;
    assign o_occurrences  = r_occ;
    assign o_first_seen   = r_first;
    assign o_last_seen    = r_last;
    assign o_stored_count = 5'(r_fill);
    assign o_active_total = 5'(r_act_cnt);
    assign o_health_score = fct_pkg::health_of(r_act_cnt);
    assign o_dropped      = r_dropped;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= fct_pkg::CntW'(fct_pkg::TableDepth))
        else $error("fill count exceeds table depth");

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_cnt <= r_fill)
        else $error("active count exceeds fill count");

    a_drop_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped |-> !o_found && (r_fill == fct_pkg::CntW'(fct_pkg::TableDepth)))
        else $error("dropped request reported as found or table not full");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_kind == fct_pkg::KindClearAll)
        |=> o_valid && (r_fill == '0) && (r_act_cnt == '0))
        else $error("clear all did not empty the table");

endmodule
